// ===== sv/two_key_press_duration_classifier_top_defines.svh =====
// Assertion macros used by the key press classifier top level.
`ifndef TWO_KEY_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH
`define TWO_KEY_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TKPDC_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("key press classifier assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TKPDC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("key press classifier assertion failed");

`endif

// ===== sv/tkpdc_pkg.sv =====
// Types and constants of the two-key press duration classifier.
`timescale 1ns / 1ps
package tkpdc_pkg;

	localparam int unsigned CountW = 10;
	localparam int unsigned CfgIndexW = 2;

	typedef logic [CountW-1:0] count_t;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_QUICK = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;
	localparam logic [1:0] EV_VLONG = 2'd3;

	localparam logic [CfgIndexW-1:0] CFG_QUICK_MIN = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_LONG      = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_VERY_LONG = 2'd2;

	localparam count_t QUICK_MIN_RESET = 10'd2;
	localparam count_t LONG_RESET      = 10'd100;
	localparam count_t VERY_LONG_RESET = 10'd1000;

	typedef struct packed {
		logic key0_level;
		logic key1_level;
		logic system_idle;
	} in_item_t;

	typedef struct packed {
		logic [1:0] key0_event;
		logic [1:0] key1_event;
		logic       shutdown_request;
	} out_item_t;

	typedef struct packed {
		count_t quick_min_ticks;
		count_t long_ticks;
		count_t very_long_ticks;
	} cfg_t;

	// Per-press state; key 1 never records a quick event on press.
	typedef struct packed {
		count_t hold0;
		count_t hold1;
		logic   quick_sent0;
		logic   shutdown_sent;
		logic   press_began_idle;
	} key_state_t;

endpackage

// ===== sv/two_key_press_duration_classifier_top.sv =====
// Top level of the two-key press duration classifier.
// A tick accepted into the input register moves into the output register when that register advances.
// Throughput: one tick per cycle; the input register advances whenever the output is free.
// Every accepted tick yields exactly one result transaction.
// Reset clears the press state, both pipeline valids and loads the default thresholds.
`timescale 1ns / 1ps
`include "two_key_press_duration_classifier_top_defines.svh"
module two_key_press_duration_classifier_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [tkpdc_pkg::CfgIndexW-1:0] cfg_index,
	input  tkpdc_pkg::count_t               cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tkpdc_pkg::in_item_t             in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tkpdc_pkg::out_item_t            out_item
);
	import tkpdc_pkg::*;

	cfg_t       cfg;
	in_item_t   item_s1;
	logic       valid_s1;
	key_state_t state_q;
	key_state_t state_next;
	out_item_t  result;
	out_item_t  out_item_q;
	logic       out_valid_q;
	logic       advance;
	logic       in_accept;

	tkpdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tkpdc_eval u_eval (
		.item       (item_s1),
		.cfg        (cfg),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	// The held tick moves on when the output register is empty or being drained.
	assign advance   = ~out_valid_q | ~out_stall;
	assign in_stall  = valid_s1 & ~advance;
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`TKPDC_ASSERT_SAME(a_shutdown_with_long, out_valid_q && out_item_q.shutdown_request,
		out_item_q.key0_event == EV_LONG)
	`TKPDC_ASSERT_SAME(a_key0_no_vlong, out_valid_q, out_item_q.key0_event != EV_VLONG)
	`TKPDC_ASSERT_SAME(a_stall_only_when_held, in_stall, valid_s1 && out_valid_q && out_stall)
	`TKPDC_ASSERT_NEXT(a_tick_reaches_output, valid_s1 && advance, out_valid_q)

endmodule

// ===== sv/tkpdc_cfg.sv =====
// Threshold registers written through the configuration port.
`timescale 1ns / 1ps
module tkpdc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [tkpdc_pkg::CfgIndexW-1:0] cfg_index,
	input  tkpdc_pkg::count_t              cfg_data,
	output tkpdc_pkg::cfg_t                cfg
);
	import tkpdc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quick_min_ticks <= QUICK_MIN_RESET;
			cfg_q.long_ticks      <= LONG_RESET;
			cfg_q.very_long_ticks <= VERY_LONG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_QUICK_MIN: cfg_q.quick_min_ticks <= cfg_data;
				CFG_LONG:      cfg_q.long_ticks      <= cfg_data;
				CFG_VERY_LONG: cfg_q.very_long_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/tkpdc_eval.sv =====
// Per-tick classification: next press state and the events of one scan tick.
`timescale 1ns / 1ps
module tkpdc_eval (
	input  tkpdc_pkg::in_item_t   item,
	input  tkpdc_pkg::cfg_t       cfg,
	input  tkpdc_pkg::key_state_t state,
	output tkpdc_pkg::key_state_t state_next,
	output tkpdc_pkg::out_item_t  result
);
	import tkpdc_pkg::*;

	localparam int unsigned StepW = CountW + 1;

	logic             pressed0;
	logic             pressed1;
	logic [StepW-1:0] step0;
	logic [StepW-1:0] step1;
	logic [StepW-1:0] quick_w;
	logic [StepW-1:0] long_w;
	logic [StepW-1:0] vlong_w;
	logic             began_idle;

	assign pressed0 = ~item.key0_level;
	assign pressed1 = ~item.key1_level;
	// One bit of headroom: the count may sit at 1023 after a lowered ceiling.
	assign step0    = {1'b0, state.hold0} + StepW'(1);
	assign step1    = {1'b0, state.hold1} + StepW'(1);
	assign quick_w  = {1'b0, cfg.quick_min_ticks};
	assign long_w   = {1'b0, cfg.long_ticks};
	assign vlong_w  = {1'b0, cfg.very_long_ticks};

	// The idle flag is latched on the first tick of a power key press.
	assign began_idle = (pressed0 && step0 == StepW'(1)) ? item.system_idle
		: state.press_began_idle;

	always_comb begin
		state_next = state;
		result     = '0;
		state_next.press_began_idle = began_idle;

		if (pressed0) begin
			if (item.system_idle && step0 == quick_w && !state.quick_sent0) begin
				result.key0_event      = EV_QUICK;
				state_next.quick_sent0 = 1'b1;
			end
			if (step0 == long_w && !began_idle) begin
				result.key0_event = EV_LONG;
				if (!state.shutdown_sent) begin
					result.shutdown_request  = 1'b1;
					state_next.shutdown_sent = 1'b1;
				end
			end
			state_next.hold0 = (step0 > vlong_w) ? cfg.very_long_ticks : step0[CountW-1:0];
		end else begin
			if (state.hold0 >= cfg.quick_min_ticks && state.hold0 < cfg.long_ticks
					&& !state.quick_sent0) begin
				result.key0_event = EV_QUICK;
			end
			state_next.hold0            = '0;
			state_next.quick_sent0      = 1'b0;
			state_next.shutdown_sent    = 1'b0;
			state_next.press_began_idle = 1'b0;
		end

		if (pressed1) begin
			if (step1 == long_w) begin
				result.key1_event = EV_LONG;
			end else if (step1 == vlong_w) begin
				result.key1_event = EV_VLONG;
			end
			state_next.hold1 = (step1 > vlong_w) ? cfg.very_long_ticks : step1[CountW-1:0];
		end else begin
			if (state.hold1 >= cfg.quick_min_ticks && state.hold1 < cfg.long_ticks) begin
				result.key1_event = EV_QUICK;
			end
			state_next.hold1 = '0;
		end
	end

endmodule
